>>> sv/lse_pkg.sv
package lse_pkg;

    // Section codes, also the internal phase of the sequencer
    localparam logic [2:0] SEC_HEADER  = 3'd0;
    localparam logic [2:0] SEC_MAGIC   = 3'd1;
    localparam logic [2:0] SEC_EXTLEN  = 3'd2;
    localparam logic [2:0] SEC_EXT     = 3'd3;
    localparam logic [2:0] SEC_SIZE    = 3'd4;
    localparam logic [2:0] SEC_PAYLOAD = 3'd5;
    localparam logic [2:0] SEC_PASS    = 3'd6;

    // Configuration register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_MAGIC_LENGTH = 2'd0;
    localparam logic [1:0] REG_EXT_LENGTH   = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_SIZE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
    localparam logic [3:0]  EXT_LENGTH_RST   = 4'd4;
    localparam logic [31:0] PAYLOAD_SIZE_RST = 32'd0;

    // Bits per hidden byte; last bit index of a 32-bit length field
    localparam logic [4:0] NARROW_BITS = 5'd8;
    localparam logic [4:0] WIDE_BITS   = 5'd31;

    // One result beat
    typedef struct packed {
        logic [7:0] stego_byte;
        logic       secret_taken;
        logic [2:0] section;
    } lse_beat_t;

endpackage

>>> sv/lsb_stego_embedder.sv
// LSB image steganography embedder. One carrier byte enters per beat and one
// stego byte leaves per beat, one beat per clock when neither side stalls; the
// result of each accepted beat is registered in a two-entry output buffer, so input
// is stalled only once both buffer entries hold unread beats. The first
// HEADER_BYTES bytes pass unchanged, then the magic bytes, the 32-bit extension
// length, the extension bytes, the 32-bit payload size and the payload bytes are
// written LSB first into carrier LSBs (eight carrier bytes per data byte), then
// everything passes through until reset. secret_byte is sampled on the first
// beat of each group of eight; secret_taken flags that beat. Empty sections are
// skipped without spending carrier bytes. Registers (APB, byte address):
// 0x0 magic_length, 0x4 ext_length, 0x8 payload_size; write only while idle.
module lsb_stego_embedder #(
    parameter int HEADER_BYTES = 54
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        carrier_valid,
    output logic        carrier_stall,
    input  logic [7:0]  carrier_byte,
    input  logic [7:0]  secret_byte,
    output logic        stego_valid,
    input  logic        stego_stall,
    output logic [7:0]  stego_byte,
    output logic        secret_taken,
    output logic [2:0]  section
);
    import lse_pkg::*;

    logic [3:0]  magic_length_reg;
    logic [3:0]  ext_length_reg;
    logic [31:0] payload_size_reg;
    logic        cfg_write;
    logic        accept;
    logic        buf_full;
    lse_beat_t   core_beat;
    lse_beat_t   out_beat;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_length_reg <= MAGIC_LENGTH_RST;
            ext_length_reg   <= EXT_LENGTH_RST;
            payload_size_reg <= PAYLOAD_SIZE_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_MAGIC_LENGTH: magic_length_reg <= pwdata[3:0];
                REG_EXT_LENGTH:   ext_length_reg   <= pwdata[3:0];
                REG_PAYLOAD_SIZE: payload_size_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MAGIC_LENGTH: prdata = {28'd0, magic_length_reg};
            REG_EXT_LENGTH:   prdata = {28'd0, ext_length_reg};
            REG_PAYLOAD_SIZE: prdata = payload_size_reg;
            default:          prdata = 32'd0;
        endcase
    end

    // Input handshake
    assign carrier_stall = buf_full;
    assign accept        = carrier_valid && !buf_full;

    lse_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .carrier_byte (carrier_byte),
        .secret_byte  (secret_byte),
        .magic_length (magic_length_reg),
        .ext_length   (ext_length_reg),
        .payload_size (payload_size_reg),
        .beat         (core_beat)
    );

    lse_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_beat (core_beat),
        .full      (buf_full),
        .out_valid (stego_valid),
        .out_stall (stego_stall),
        .out_beat  (out_beat)
    );

    assign stego_byte   = out_beat.stego_byte;
    assign secret_taken = out_beat.secret_taken;
    assign section      = out_beat.section;

endmodule

>>> sv/lse_core.sv
module lse_core #(
    parameter int HEADER_BYTES = 54
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        carrier_byte,
    input  logic [7:0]        secret_byte,
    input  logic [3:0]        magic_length,
    input  logic [3:0]        ext_length,
    input  logic [31:0]       payload_size,
    output lse_pkg::lse_beat_t beat
);
    import lse_pkg::*;

    localparam logic [31:0] HeaderCount = 32'(HEADER_BYTES);

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [4:0]  bit_reg, bit_next;
    logic [7:0]  held_reg, held_next;

    logic [2:0]  ph;
    logic [31:0] cnt;
    logic [4:0]  bi;
    logic        wide;
    logic        hiding;
    logic        taken;
    logic        data_bit;
    logic [4:0]  bi_inc;

    // Section end test against the current register values
    function automatic logic sec_done(input logic [2:0] p, input logic [31:0] c,
                                      input logic [3:0] ml, input logic [3:0] el,
                                      input logic [31:0] ps);
        logic d;
        begin
            d = 1'b0;
            case (p)
                SEC_HEADER:  d = (c >= HeaderCount);
                SEC_MAGIC:   d = (c >= {28'd0, ml});
                SEC_EXTLEN:  d = (c != 32'd0);
                SEC_EXT:     d = (c >= {28'd0, el});
                SEC_SIZE:    d = (c != 32'd0);
                SEC_PAYLOAD: d = (c >= ps);
                default:     d = 1'b0;
            endcase
            return d;
        end
    endfunction

    // Settle: skip finished and empty sections before using the beat
    always_comb
    begin
        ph  = phase_reg;
        cnt = count_reg;
        bi  = bit_reg;
        for (int i = 0; i < 7; i++)
        begin
            if (ph < SEC_PASS && sec_done(ph, cnt, magic_length, ext_length, payload_size))
            begin
                ph  = ph + 3'd1;
                cnt = 32'd0;
                bi  = 5'd0;
            end
        end
    end

    // Bit selection and counter update
    always_comb
    begin
        wide   = (ph == SEC_EXTLEN) || (ph == SEC_SIZE);
        hiding = (ph != SEC_HEADER) && (ph != SEC_PASS);
        taken  = hiding && !wide && (bi == 5'd0);
        held_next = taken ? secret_byte : held_reg;

        case (ph)
            SEC_EXTLEN: data_bit = (bi < 5'd4) ? ext_length[bi[1:0]] : 1'b0;
            SEC_SIZE:   data_bit = payload_size[bi];
            default:    data_bit = held_next[bi[2:0]];
        endcase

        bi_inc     = bi + 5'd1;
        phase_next = ph;
        count_next = cnt;
        bit_next   = bi;
        if (ph == SEC_HEADER)
        begin
            count_next = cnt + 32'd1;
        end
        else if (hiding)
        begin
            if ((wide && bi == WIDE_BITS) || (!wide && bi_inc >= NARROW_BITS))
            begin
                bit_next   = 5'd0;
                count_next = cnt + 32'd1;
            end
            else
            begin
                bit_next = bi_inc;
            end
        end

        beat.stego_byte   = hiding ? {carrier_byte[7:1], data_bit} : carrier_byte;
        beat.secret_taken = taken;
        beat.section      = ph;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= SEC_HEADER;
            count_reg <= 32'd0;
            bit_reg   <= 5'd0;
            held_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            bit_reg   <= bit_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> sv/lse_skid.sv
module lse_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lse_pkg::lse_beat_t push_beat,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output lse_pkg::lse_beat_t out_beat
);
    import lse_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    lse_beat_t main_reg, main_next;
    lse_beat_t skid_reg, skid_next;
    logic      pop;

    // Two-entry output buffer; push only when the skid slot is free
    always_comb
    begin
        pop             = main_valid_reg && !out_stall;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            main_valid_next = skid_valid_reg;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!main_valid_next)
            begin
                main_valid_next = 1'b1;
                main_next       = push_beat;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_beat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_beat  = main_reg;

endmodule
